/* sv/assert_macros.svh */
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define BFC_ASSERT_NOW(lbl, expr, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (expr)) else $error(msg);
`define BFC_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define BFC_ASSERT_NOW(lbl, expr, msg)
`define BFC_ASSERT_NEXT(lbl, ante, cons, msg)
`endif
`endif

/* sv/bfc_pkg.sv */
package bfc_pkg;
    localparam int CORNER_COUNT = 8;
    localparam int MATRIX_ROWS  = 4;
    localparam int CORNER_W     = 3;
    localparam logic [1:0] REQ_PLANE  = 2'd0;
    localparam logic [1:0] REQ_MATRIX = 2'd1;
    localparam logic [1:0] REQ_CULL   = 2'd2;
    localparam logic [1:0] REQ_RSVD   = 2'd3;
    localparam logic signed [31:0] Q_ONE = 32'sh0001_0000;
    localparam logic [CORNER_W-1:0] LAST_CORNER = 3'd7;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RUN,
        ST_WAIT
    } t_state;

    typedef struct packed {
        logic vld;
        logic first;
        logic last;
    } t_stage;
endpackage

/* sv/bfc_xform_lane.sv */
module bfc_xform_lane import bfc_pkg::*; #(
    parameter int COORD_WIDTH = 32
) (
    input  logic               i_clk,
    input  logic signed [31:0] i_x,
    input  logic signed [31:0] i_y,
    input  logic signed [31:0] i_z,
    input  logic signed [31:0] i_m0,
    input  logic signed [31:0] i_m1,
    input  logic signed [31:0] i_m2,
    input  logic signed [31:0] i_t,
    output logic signed [31:0] o_world
);
    localparam logic signed [50:0] LIM_HI = (51'sd1 <<< (COORD_WIDTH - 1)) - 51'sd1;
    localparam logic signed [50:0] LIM_LO = -LIM_HI - 51'sd1;

    logic signed [63:0] r_p0, r_p1, r_p2;
    logic signed [31:0] r_world;
    logic signed [65:0] sum;
    logic signed [49:0] fl;
    logic signed [50:0] tot;
    logic signed [50:0] sat;

    always_ff @(posedge i_clk) begin
        r_p0    <= i_x * i_m0;
        r_p1    <= i_y * i_m1;
        r_p2    <= i_z * i_m2;
        r_world <= sat[31:0];
    end

    always_comb begin
        sum = 66'(r_p0) + 66'(r_p1) + 66'(r_p2);
        fl  = sum[65:16];
        tot = 51'(fl) + 51'(i_t);
        if (tot > LIM_HI) begin
            sat = LIM_HI;
        end else if (tot < LIM_LO) begin
            sat = LIM_LO;
        end else begin
            sat = tot;
        end
    end

    assign o_world = r_world;
endmodule

/* sv/bfc_plane_lane.sv */
module bfc_plane_lane import bfc_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  t_stage             i_stage,
    input  logic signed [31:0] i_x,
    input  logic signed [31:0] i_y,
    input  logic signed [31:0] i_z,
    input  logic signed [31:0] i_nx,
    input  logic signed [31:0] i_ny,
    input  logic signed [31:0] i_nz,
    input  logic signed [31:0] i_d,
    output logic               o_all_behind
);
    logic signed [63:0] r_p0, r_p1, r_p2;
    logic               r_all;
    logic signed [66:0] dist_sum;
    logic               behind;

    always_ff @(posedge i_clk) begin
        r_p0 <= i_nx * i_x;
        r_p1 <= i_ny * i_y;
        r_p2 <= i_nz * i_z;
    end

    assign dist_sum = 67'(r_p0) + 67'(r_p1) + 67'(r_p2) + 67'(signed'({i_d, 16'h0000}));
    assign behind   = dist_sum[66];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_all <= 1'b0;
        end else if (i_stage.vld) begin
            r_all <= i_stage.first ? behind : (r_all & behind);
        end
    end

    assign o_all_behind = r_all;
endmodule

/* sv/box_transform_frustum_cull_unit.sv */
// box transform and frustum cull
// input channel: i_valid / o_stall with i_req_type, i_slot_index, the four
// coefficients and the six local box bounds. plane and matrix writes give no
// result; a cull item gives one result on the output channel o_valid /
// i_stall: o_in_frustum and the world-space bounds.
// a cull item walks its eight corners through the matrix lanes, one corner a
// cycle, then through one plane lane per plane; the load of the output register
// sets o_in_frustum to the nor of the lanes' all-behind flags. the next item
// is taken in the cycle after the result is loaded, so a new box is not taken
// before the last one is through; the time per box is set by the corner loop,
// the four-stage multiply pipeline and the load of the output register.
// the result sits in an output register; while the receiver stalls it holds,
// and a new item is still taken once the result has been loaded there. a
// second result waits in the pipeline until the register frees.
// reset loads the identity matrix, clears all planes (every box is then in
// the frustum) and empties the pipeline and the output register.
module box_transform_frustum_cull_unit import bfc_pkg::*; #(
    parameter int PLANE_COUNT = 6,
    parameter int COORD_WIDTH = 32
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_stall,
    input  logic [1:0]         i_req_type,
    input  logic [2:0]         i_slot_index,
    input  logic signed [31:0] i_coef_x,
    input  logic signed [31:0] i_coef_y,
    input  logic signed [31:0] i_coef_z,
    input  logic signed [31:0] i_coef_w,
    input  logic signed [31:0] i_box_min_x,
    input  logic signed [31:0] i_box_min_y,
    input  logic signed [31:0] i_box_min_z,
    input  logic signed [31:0] i_box_max_x,
    input  logic signed [31:0] i_box_max_y,
    input  logic signed [31:0] i_box_max_z,
    output logic               o_valid,
    input  logic               i_stall,
    output logic               o_in_frustum,
    output logic signed [31:0] o_world_min_x,
    output logic signed [31:0] o_world_min_y,
    output logic signed [31:0] o_world_min_z,
    output logic signed [31:0] o_world_max_x,
    output logic signed [31:0] o_world_max_y,
    output logic signed [31:0] o_world_max_z
);
`include "assert_macros.svh"

    logic signed [31:0] r_mat [16];
    logic signed [31:0] r_pln [PLANE_COUNT*4];
    logic signed [31:0] r_lo [3];
    logic signed [31:0] r_hi [3];
    logic signed [31:0] r_min [3];
    logic signed [31:0] r_max [3];
    logic signed [31:0] r_out_min [3];
    logic signed [31:0] r_out_max [3];
    logic               r_out_in;
    logic               r_out_vld;
    t_state             r_state, n_state;
    logic [CORNER_W-1:0] r_cnt, n_cnt;
    t_stage             r_s1, r_s2, r_s3, issue;
    logic               r_done, r_fin, n_fin;
    logic               load;
    logic               acc_in;
    logic               pipe_busy;
    logic signed [31:0] corner [3];
    logic signed [31:0] world [3];
    logic [PLANE_COUNT-1:0] all_behind;

    assign acc_in    = i_valid && !o_stall;
    assign o_stall   = (r_state != ST_IDLE);
    assign pipe_busy = r_s1.vld || r_s2.vld || r_s3.vld;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < 16; i++) begin
                r_mat[i] <= (i % 5 == 0) ? Q_ONE : 32'sd0;
            end
            for (int i = 0; i < PLANE_COUNT*4; i++) begin
                r_pln[i] <= 32'sd0;
            end
        end else if (acc_in && i_req_type == REQ_MATRIX) begin
            for (int r = 0; r < MATRIX_ROWS; r++) begin
                if (i_slot_index == 3'(r)) begin
                    r_mat[4*r]   <= i_coef_x;
                    r_mat[4*r+1] <= i_coef_y;
                    r_mat[4*r+2] <= i_coef_z;
                    r_mat[4*r+3] <= i_coef_w;
                end
            end
        end else if (acc_in && i_req_type == REQ_PLANE) begin
            for (int p = 0; p < PLANE_COUNT; p++) begin
                if (4'(i_slot_index) == 4'(p)) begin
                    r_pln[4*p]   <= i_coef_x;
                    r_pln[4*p+1] <= i_coef_y;
                    r_pln[4*p+2] <= i_coef_z;
                    r_pln[4*p+3] <= i_coef_w;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (acc_in && i_req_type == REQ_CULL) begin
            r_lo[0] <= i_box_min_x;
            r_lo[1] <= i_box_min_y;
            r_lo[2] <= i_box_min_z;
            r_hi[0] <= i_box_max_x;
            r_hi[1] <= i_box_max_y;
            r_hi[2] <= i_box_max_z;
        end
    end

    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        n_fin   = r_fin;
        load    = 1'b0;
        issue   = '0;
        case (r_state)
            ST_IDLE: begin
                n_cnt = '0;
                n_fin = 1'b0;
                if (acc_in && i_req_type == REQ_CULL) begin
                    n_state = ST_RUN;
                end
            end
            ST_RUN: begin
                issue.vld   = 1'b1;
                issue.first = (r_cnt == '0);
                issue.last  = (r_cnt == LAST_CORNER);
                n_cnt       = r_cnt + 1'b1;
                if (r_cnt == LAST_CORNER) begin
                    n_state = ST_WAIT;
                end
            end
            ST_WAIT: begin
                if (r_done) begin
                    n_fin = 1'b1;
                end
                if ((r_done || r_fin) && (!r_out_vld || !i_stall)) begin
                    load    = 1'b1;
                    n_fin   = 1'b0;
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_cnt     <= '0;
            r_fin     <= 1'b0;
            r_s1      <= '0;
            r_s2      <= '0;
            r_s3      <= '0;
            r_done    <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
            r_fin   <= n_fin;
            r_s1    <= issue;
            r_s2    <= r_s1;
            r_s3    <= r_s2;
            r_done  <= r_s3.vld && r_s3.last;
            if (load) begin
                r_out_vld <= 1'b1;
            end else if (!i_stall) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    // corner bits pick max (1) or min (0) per axis
    always_comb begin
        for (int k = 0; k < 3; k++) begin
            corner[k] = r_cnt[k] ? r_hi[k] : r_lo[k];
        end
    end

    for (genvar a = 0; a < 3; a++) begin : g_xform
        bfc_xform_lane #(.COORD_WIDTH(COORD_WIDTH)) u_lane (
            .i_clk   (i_clk),
            .i_x     (corner[0]),
            .i_y     (corner[1]),
            .i_z     (corner[2]),
            .i_m0    (r_mat[a]),
            .i_m1    (r_mat[4+a]),
            .i_m2    (r_mat[8+a]),
            .i_t     (r_mat[12+a]),
            .o_world (world[a])
        );
    end

    for (genvar p = 0; p < PLANE_COUNT; p++) begin : g_plane
        bfc_plane_lane u_lane (
            .i_clk        (i_clk),
            .i_rst_n      (i_rst_n),
            .i_stage      (r_s3),
            .i_x          (world[0]),
            .i_y          (world[1]),
            .i_z          (world[2]),
            .i_nx         (r_pln[4*p]),
            .i_ny         (r_pln[4*p+1]),
            .i_nz         (r_pln[4*p+2]),
            .i_d          (r_pln[4*p+3]),
            .o_all_behind (all_behind[p])
        );
    end

    always_ff @(posedge i_clk) begin
        if (r_s2.vld) begin
            for (int k = 0; k < 3; k++) begin
                if (r_s2.first || world[k] < r_min[k]) begin
                    r_min[k] <= world[k];
                end
                if (r_s2.first || world[k] > r_max[k]) begin
                    r_max[k] <= world[k];
                end
            end
        end
        if (load) begin
            r_out_in <= ~|all_behind;
            for (int k = 0; k < 3; k++) begin
                r_out_min[k] <= r_min[k];
                r_out_max[k] <= r_max[k];
            end
        end
    end

    assign o_valid       = r_out_vld;
    assign o_in_frustum  = r_out_in;
    assign o_world_min_x = r_out_min[0];
    assign o_world_min_y = r_out_min[1];
    assign o_world_min_z = r_out_min[2];
    assign o_world_max_x = r_out_max[0];
    assign o_world_max_y = r_out_max[1];
    assign o_world_max_z = r_out_max[2];

    `BFC_ASSERT_NOW(a_done_in_wait, !r_done || r_state == ST_WAIT, "result done outside wait")
    `BFC_ASSERT_NOW(a_idle_empty, r_state != ST_IDLE || !pipe_busy, "pipeline busy while idle")
    `BFC_ASSERT_NEXT(a_load_valid, load, r_out_vld && r_state == ST_IDLE, "load lost")
    `BFC_ASSERT_NOW(a_run_start, !(r_state == ST_RUN && r_cnt == '0) || !r_s1.vld, "issue overlap")
endmodule

/* tb/sv/tb_box_transform_frustum_cull_unit.sv */
`timescale 1ns / 100ps

module tb_box_transform_frustum_cull_unit import bfc_pkg::*; ();

    localparam int NUM_PLANES = 6;
    localparam int CYCLE_LIMIT = 400000;

    typedef struct {
        logic [1:0]         req;
        logic [2:0]         slot;
        logic signed [31:0] coef [4];
        logic signed [31:0] bmin [3];
        logic signed [31:0] bmax [3];
    } t_item;

    typedef struct {
        logic               in_fr;
        logic signed [31:0] wmin [3];
        logic signed [31:0] wmax [3];
    } t_bounds;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               i_valid = 1'b0;
    logic               o_stall;
    logic [1:0]         i_req_type = '0;
    logic [2:0]         i_slot_index = '0;
    logic signed [31:0] i_coef_x = '0, i_coef_y = '0, i_coef_z = '0, i_coef_w = '0;
    logic signed [31:0] i_box_min_x = '0, i_box_min_y = '0, i_box_min_z = '0;
    logic signed [31:0] i_box_max_x = '0, i_box_max_y = '0, i_box_max_z = '0;
    logic               o_valid;
    logic               i_stall = 1'b0;
    logic               o_in_frustum;
    logic signed [31:0] o_world_min_x, o_world_min_y, o_world_min_z;
    logic signed [31:0] o_world_max_x, o_world_max_y, o_world_max_z;

    box_transform_frustum_cull_unit dut (.*);

    always #2 i_clk = ~i_clk;

    t_item   pending_items[$];
    t_bounds expected_bounds[$];
    logic signed [31:0] world_mat [16];
    logic signed [31:0] plane_coef [NUM_PLANES*4];
    int send_idle = 11;
    int recv_idle = 72;
    int run_phase = 1;
    int mismatches = 0;
    int cycles = 0;
    int hold_left = 0;
    bit hold_done = 0;

    function automatic void queue_item(t_item it);
        pending_items = {pending_items, it};
    endfunction

    function automatic logic signed [31:0] xform_axis(logic signed [31:0] pt [3], int a);
        logic signed [79:0] acc, p, m, top, bot;
        acc = world_mat[12+a];
        acc = acc <<< 16;
        for (int k = 0; k < 3; k++) begin
            p = pt[k];
            m = world_mat[4*k+a];
            acc = acc + p * m;
        end
        acc = acc >>> 16;
        top = 80'sh7fff_ffff;
        bot = -top - 1;
        if (acc > top) acc = top;
        if (acc < bot) acc = bot;
        return acc[31:0];
    endfunction

    function automatic bit is_behind(logic signed [31:0] pt [3], int pl);
        logic signed [79:0] acc, p, n;
        acc = plane_coef[4*pl+3];
        acc = acc <<< 16;
        for (int k = 0; k < 3; k++) begin
            p = pt[k];
            n = plane_coef[4*pl+k];
            acc = acc + p * n;
        end
        return acc < 0;
    endfunction

    task automatic apply_item(t_item it);
        logic signed [31:0] corner [8][3];
        logic signed [31:0] pt [3];
        t_bounds r;
        bit all_behind;
        if (it.req == REQ_PLANE && it.slot < NUM_PLANES) begin
            for (int k = 0; k < 4; k++) plane_coef[4*it.slot+k] = it.coef[k];
        end else if (it.req == REQ_MATRIX && it.slot < MATRIX_ROWS) begin
            for (int k = 0; k < 4; k++) world_mat[4*it.slot+k] = it.coef[k];
        end else if (it.req == REQ_CULL) begin
            for (int c = 0; c < CORNER_COUNT; c++) begin
                for (int k = 0; k < 3; k++) pt[k] = ((c >> k) & 1) ? it.bmax[k] : it.bmin[k];
                for (int k = 0; k < 3; k++) begin
                    corner[c][k] = xform_axis(pt, k);
                    if (c == 0 || corner[c][k] < r.wmin[k]) r.wmin[k] = corner[c][k];
                    if (c == 0 || corner[c][k] > r.wmax[k]) r.wmax[k] = corner[c][k];
                end
            end
            r.in_fr = 1'b1;
            for (int pl = 0; pl < NUM_PLANES; pl++) begin
                all_behind = 1;
                for (int c = 0; c < CORNER_COUNT; c++) begin
                    for (int k = 0; k < 3; k++) pt[k] = corner[c][k];
                    if (!is_behind(pt, pl)) all_behind = 0;
                end
                if (all_behind) r.in_fr = 1'b0;
            end
            expected_bounds = {expected_bounds, r};
        end
    endtask

    // driver
    always @(posedge i_clk) begin
        t_item it;
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else begin
            if (i_valid && !o_stall) begin
                it.req = i_req_type;
                it.slot = i_slot_index;
                it.coef = '{i_coef_x, i_coef_y, i_coef_z, i_coef_w};
                it.bmin = '{i_box_min_x, i_box_min_y, i_box_min_z};
                it.bmax = '{i_box_max_x, i_box_max_y, i_box_max_z};
                apply_item(it);
            end
            if (i_valid && o_stall) begin
                i_valid <= 1'b1;
            end else if (pending_items.size() > 0 && $urandom_range(99) >= send_idle) begin
                it = pending_items.pop_front();
                i_valid <= 1'b1;
                i_req_type <= it.req;
                i_slot_index <= it.slot;
                i_coef_x <= it.coef[0];
                i_coef_y <= it.coef[1];
                i_coef_z <= it.coef[2];
                i_coef_w <= it.coef[3];
                i_box_min_x <= it.bmin[0];
                i_box_min_y <= it.bmin[1];
                i_box_min_z <= it.bmin[2];
                i_box_max_x <= it.bmax[0];
                i_box_max_y <= it.bmax[1];
                i_box_max_z <= it.bmax[2];
            end else begin
                i_valid <= 1'b0;
            end
        end
    end

    // monitor
    always @(posedge i_clk) begin
        t_bounds e;
        logic signed [31:0] got [6];
        cycles <= cycles + 1;
        if (i_rst_n && o_valid && !i_stall) begin
            got = '{o_world_min_x, o_world_min_y, o_world_min_z,
                    o_world_max_x, o_world_max_y, o_world_max_z};
            if (expected_bounds.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected result at cycle %0d", cycles);
            end else begin
                e = expected_bounds.pop_front();
                if (e.in_fr !== o_in_frustum
                    || e.wmin[0] !== got[0] || e.wmin[1] !== got[1] || e.wmin[2] !== got[2]
                    || e.wmax[0] !== got[3] || e.wmax[1] !== got[4] || e.wmax[2] !== got[5])
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display({"mismatch: exp in=%0d min=%0d,%0d,%0d max=%0d,%0d,%0d",
                                  " got in=%0d min=%0d,%0d,%0d max=%0d,%0d,%0d"},
                                 e.in_fr, e.wmin[0], e.wmin[1], e.wmin[2],
                                 e.wmax[0], e.wmax[1], e.wmax[2], o_in_frustum,
                                 got[0], got[1], got[2], got[3], got[4], got[5]);
                end
            end
        end
        // long hold-off once in the last phase so the pipeline backs up
        if (run_phase == 3 && !hold_done && hold_left == 0) begin
            hold_left <= 300;
            hold_done <= 1;
            i_stall <= 1'b1;
        end else if (hold_left > 1) begin
            hold_left <= hold_left - 1;
            i_stall <= 1'b1;
        end else begin
            hold_left <= 0;
            i_stall <= ($urandom_range(99) < recv_idle);
        end
        if (cycles > CYCLE_LIMIT) begin
            $display("FAIL box_transform_frustum_cull_unit");
            $finish;
        end
    end

    function automatic logic signed [31:0] rand_coord();
        case ($urandom_range(9))
            0: return 32'sh7fff_ffff;
            1: return 32'sh8000_0000;
            2, 3: return $urandom;
            default: return $signed($urandom_range(32'h0040_0000)) - 32'sh0020_0000;
        endcase
    endfunction

    function automatic t_item make_item(logic [1:0] req, logic [2:0] slot);
        t_item it;
        it.req = req;
        it.slot = slot;
        for (int k = 0; k < 4; k++) it.coef[k] = rand_coord();
        for (int k = 0; k < 3; k++) begin
            it.bmin[k] = rand_coord();
            it.bmax[k] = ($urandom_range(9) == 0) ? rand_coord()
                         : it.bmin[k] + $signed({1'b0, $urandom_range(32'h0008_0000)});
        end
        return it;
    endfunction

    task automatic add_random(int n);
        t_item it;
        for (int i = 0; i < n; i++) begin
            case ($urandom_range(19))
                0, 1: it = make_item(REQ_PLANE, $urandom_range(7));
                2: begin
                    it = make_item(REQ_MATRIX, $urandom_range(7));
                    // keep most matrices near unit scale
                    if ($urandom_range(3) != 0)
                        for (int k = 0; k < 3; k++)
                            it.coef[k] = $signed($urandom_range(32'h0002_0000)) - Q_ONE;
                end
                3: it = make_item(REQ_RSVD, $urandom_range(7));
                default: it = make_item(REQ_CULL, 0);
            endcase
            queue_item(it);
        end
    endtask

    task automatic wait_drained();
        while (pending_items.size() > 0 || i_valid || expected_bounds.size() > 0)
            @(posedge i_clk);
        repeat (20) @(posedge i_clk);
    endtask

    initial begin
        t_item it;
        for (int i = 0; i < 16; i++) world_mat[i] = (i % 5 == 0) ? Q_ONE : '0;
        for (int i = 0; i < NUM_PLANES*4; i++) plane_coef[i] = '0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // zero planes: every box inside, extreme corners through identity
        it = make_item(REQ_CULL, 0);
        it.bmin = '{32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000};
        it.bmax = '{32'sh7fff_ffff, 32'sh7fff_ffff, 32'sh7fff_ffff};
        queue_item(it);
        it.bmin = '{32'sh7fff_ffff, 32'sh0, 32'sh8000_0000};
        it.bmax = '{32'sh8000_0000, 32'sh1, 32'sh7fff_ffff};
        queue_item(it);
        // plane x >= 0 then boxes on both sides
        it = make_item(REQ_PLANE, 0);
        it.coef = '{Q_ONE, 32'sh0, 32'sh0, 32'sh0};
        queue_item(it);
        it = make_item(REQ_CULL, 0);
        it.bmin = '{-32'sh0005_0000, 32'sh0, 32'sh0};
        it.bmax = '{-32'sh0001_0000, Q_ONE, Q_ONE};
        queue_item(it);
        it.bmax[0] = 32'sh0;
        queue_item(it);
        it.bmax[0] = -32'sh1;
        queue_item(it);
        // ignored writes and unknown request
        queue_item(make_item(REQ_PLANE, 3'd6));
        queue_item(make_item(REQ_PLANE, 3'd7));
        queue_item(make_item(REQ_MATRIX, 3'd4));
        queue_item(make_item(REQ_MATRIX, 3'd7));
        queue_item(make_item(REQ_RSVD, 3'd0));
        // large matrix for saturation, all rows
        for (int r = 0; r < MATRIX_ROWS; r++) begin
            it = make_item(REQ_MATRIX, r);
            it.coef = '{32'sh7fff_ffff, 32'sh8000_0000, Q_ONE, 32'sh7fff_ffff};
            queue_item(it);
        end
        for (int i = 0; i < 3; i++) queue_item(make_item(REQ_CULL, 0));
        for (int pl = 0; pl < NUM_PLANES; pl++) queue_item(make_item(REQ_PLANE, pl));
        queue_item(make_item(REQ_CULL, 0));
        add_random(170);
        wait_drained();

        run_phase = 2;
        send_idle = 72;
        recv_idle = 11;
        add_random(160);
        wait_drained();

        run_phase = 3;
        send_idle = 0;
        recv_idle = 0;
        add_random(160);
        wait_drained();
        repeat (30) @(posedge i_clk);

        if (mismatches == 0 && expected_bounds.size() == 0)
            $display("PASS box_transform_frustum_cull_unit");
        else
            $display("FAIL box_transform_frustum_cull_unit");
        $finish;
    end
endmodule

/* sim.f */
+incdir+sv
sv/bfc_pkg.sv
sv/bfc_xform_lane.sv
sv/bfc_plane_lane.sv
sv/box_transform_frustum_cull_unit.sv
tb/sv/tb_box_transform_frustum_cull_unit.sv
